@@ rtl/core/vsd_pkg.sv @@
// Package for the varint stream decoder: format and status codes, state and result types.
package vsd_pkg;

    localparam logic [1:0] FMT_U64 = 2'd0;
    localparam logic [1:0] FMT_U32 = 2'd1;
    localparam logic [1:0] FMT_U31 = 2'd2;
    localparam logic [1:0] FMT_S64 = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_FORMAT    = 2'd2;
    localparam logic [1:0] ST_TOO_BIG   = 2'd3;

    localparam logic [3:0] LAST_IDX_64 = 4'd9;
    localparam logic [3:0] LAST_IDX_32 = 4'd4;

    localparam logic [7:0] LIMIT_U64 = 8'd1;
    localparam logic [7:0] LIMIT_U32 = 8'd15;
    localparam logic [7:0] LIMIT_U31 = 8'd7;
    localparam logic [7:0] LIMIT_S64 = 8'd2;

    typedef struct packed {
        logic [63:0] acc;
        logic [3:0]  idx;
        logic        neg;
    } t_dec_state;

    typedef struct packed {
        logic        emit;
        logic [63:0] value;
        logic [3:0]  count;
        logic [1:0]  status;
    } t_dec_result;

endpackage

@@ rtl/core/vsd_step.sv @@
// Combinational decode of one byte against the current decoder state.
module vsd_step (
    input  logic [1:0]           i_mode,
    input  logic [7:0]           i_byte,
    input  logic                 i_end,
    input  vsd_pkg::t_dec_state  i_state,
    output vsd_pkg::t_dec_state  o_state,
    output vsd_pkg::t_dec_result o_result
);

    logic        s64;
    logic [3:0]  last_idx;
    logic [7:0]  limit;
    logic [3:0]  cnt_next;
    logic [5:0]  sh;
    logic [63:0] acc_add;
    logic [63:0] top_bits;
    logic [63:0] raw;
    logic [63:0] fixed;

    always_comb begin
        s64      = (i_mode == vsd_pkg::FMT_S64);
        last_idx = (i_mode == vsd_pkg::FMT_U64 || s64) ? vsd_pkg::LAST_IDX_64
                                                       : vsd_pkg::LAST_IDX_32;
        case (i_mode)
            vsd_pkg::FMT_U64: limit = vsd_pkg::LIMIT_U64;
            vsd_pkg::FMT_U32: limit = vsd_pkg::LIMIT_U32;
            vsd_pkg::FMT_U31: limit = vsd_pkg::LIMIT_U31;
            default:          limit = vsd_pkg::LIMIT_S64;
        endcase
        cnt_next = i_state.idx + 4'd1;
        sh       = 6'({2'b00, i_state.idx} * 6'd7) - {5'd0, s64};
        acc_add  = i_state.acc | (64'({57'd0, i_byte[6:0]}) << sh);
        case (i_mode)
            vsd_pkg::FMT_U64: top_bits = {1'b1, 63'd0};
            vsd_pkg::FMT_S64: top_bits = {i_byte[1:0], 62'd0};
            default:          top_bits = 64'({60'd0, i_byte[3:0]}) << 28;
        endcase

        raw = acc_add;
        if (i_state.idx == 4'd0) begin
            raw = s64 ? {58'd0, i_byte[6:1]} : {56'd0, i_byte};
        end else if (i_state.idx >= last_idx) begin
            raw = i_state.acc | top_bits;
        end
        fixed = (s64 && ((i_state.idx == 4'd0) ? i_byte[0] : i_state.neg))
              ? (64'd0 - raw) : raw;

        o_state         = i_state;
        o_result.emit   = 1'b0;
        o_result.value  = 64'd0;
        o_result.count  = cnt_next;
        o_result.status = vsd_pkg::ST_OK;

        if (i_state.idx == 4'd0) begin
            if (s64 && i_byte == 8'd1) begin
                o_result.emit   = 1'b1;
                o_result.status = vsd_pkg::ST_FORMAT;
            end else if (!i_byte[7]) begin
                o_result.emit  = 1'b1;
                o_result.value = fixed;
            end else begin
                o_state.acc = s64 ? {58'd0, i_byte[6:1]} : {57'd0, i_byte[6:0]};
                o_state.neg = s64 & i_byte[0];
                o_state.idx = 4'd1;
                if (i_end) begin
                    o_result.emit   = 1'b1;
                    o_result.status = vsd_pkg::ST_TRUNCATED;
                end
            end
        end else if (i_byte == 8'd0) begin
            o_result.emit   = 1'b1;
            o_result.status = vsd_pkg::ST_FORMAT;
        end else if (i_state.idx >= last_idx) begin
            o_result.emit  = 1'b1;
            o_result.count = last_idx + 4'd1;
            if (i_byte > limit) begin
                o_result.status = vsd_pkg::ST_TOO_BIG;
            end else begin
                o_result.value = fixed;
            end
        end else if (!i_byte[7]) begin
            o_result.emit  = 1'b1;
            o_result.value = fixed;
        end else begin
            o_state.acc = acc_add;
            o_state.idx = cnt_next;
            if (i_end) begin
                o_result.emit   = 1'b1;
                o_result.status = vsd_pkg::ST_TRUNCATED;
            end
        end

        if (o_result.emit) begin
            o_state.acc = 64'd0;
            o_state.idx = 4'd0;
            o_state.neg = 1'b0;
        end
    end

endmodule

@@ rtl/core/varint_stream_decoder.sv @@
// Top level of the varint stream decoder: input register, decode step, result register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  input    | i_valid / o_ready        | i_data_byte, i_buffer_end
//  result   | o_valid / i_ready        | o_decoded_value, o_byte_count, o_status
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_data (format mode)
//
// One byte per cycle while results are taken; a finished value goes to the result register.
// The decode of a byte is one pass through the step logic between the two registers.
// Synchronous active-low reset clears state and mode; no clearing pass.
// A stalled result holds the step stage; the input register then fills and o_ready drops.
module varint_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_decoded_value,
    output logic [3:0]  o_byte_count,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_in_end;
    logic [1:0]           r_mode;
    vsd_pkg::t_dec_state  r_state;
    vsd_pkg::t_dec_state  n_state;
    vsd_pkg::t_dec_result n_result;
    logic                 r_out_valid;
    logic [63:0]          r_out_value;
    logic [3:0]           r_out_count;
    logic [1:0]           r_out_status;
    logic                 adv;
    logic                 cfg_wr;

    vsd_step u_step (
        .i_mode   (r_mode),
        .i_byte   (r_in_byte),
        .i_end    (r_in_end),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign adv         = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= vsd_pkg::FMT_U64;
            r_state     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= n_result.emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                r_mode  <= i_cfg_data;
                r_state <= '0;
            end else if (adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_buffer_end;
        end
        if (adv && n_result.emit) begin
            r_out_value  <= n_result.value;
            r_out_count  <= n_result.count;
            r_out_status <= n_result.status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_decoded_value = r_out_value;
    assign o_byte_count    = r_out_count;
    assign o_status        = r_out_status;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.idx <= vsd_pkg::LAST_IDX_64)
        else $error("byte index past last position");

    a_idx_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == vsd_pkg::FMT_U32 || r_mode == vsd_pkg::FMT_U31)
            |-> r_state.idx <= vsd_pkg::LAST_IDX_32)
        else $error("byte index past last position in 32-bit mode");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != vsd_pkg::ST_OK) |-> o_decoded_value == 64'd0)
        else $error("error result carries nonzero value");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_count >= 4'd1 && o_byte_count <= 4'd10))
        else $error("byte count out of range");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state.idx == 4'd0 && !r_state.neg))
        else $error("mode write did not drop partial value");

endmodule
